### src/pp2m_pkg.sv
// ----------------------------------------------------------------------------
// pp2m_pkg: shared types and constants for the pad pressure to MIDI block
// Word layouts, state codes, MIDI status codes and register indexes.
// ----------------------------------------------------------------------------
package pp2m_pkg;

    localparam int PAD_COUNT_DEF = 48;
    localparam int NOTE_COUNT    = 128;
    localparam int PAD_W         = 6;
    localparam int NOTE_W        = 7;

    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_POLY_AT  = 8'hA0;
    localparam logic [7:0] ST_CC       = 8'hB0;
    localparam logic [6:0] VEL_FIXED   = 7'd100;

    localparam logic [1:0] LED_NONE = 2'd0;
    localparam logic [1:0] LED_ON   = 2'd1;
    localparam logic [1:0] LED_OFF  = 2'd2;

    localparam logic [1:0] MODE_MONO_CC = 2'd0;
    localparam logic [1:0] MODE_POLY_AT = 2'd1;
    localparam logic [1:0] MODE_POLY_CC = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    localparam logic [1:0] CFG_USE_VELOCITY = 2'd0;
    localparam logic [1:0] CFG_PAD_MODE     = 2'd1;
    localparam logic [1:0] CFG_MONO_CC      = 2'd2;
    localparam logic [1:0] CFG_OCTAVE       = 2'd3;

    typedef struct packed {
        logic [5:0] pad_id;
        logic [7:0] pad_value;
        logic       velocity_event;
        logic [3:0] event_channel;
        logic [6:0] mapped_note;
        logic       note_active;
        logic [7:0] full_scale;
    } t_in_word;

    typedef struct packed {
        logic       msg_valid;
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic [1:0] led_action;
        logic       last_result;
    } t_out_word;

    // one held pad in the stack chain
    typedef struct packed {
        logic [5:0] pad_id;
        logic [7:0] level;
    } t_entry;

    // level update broadcast to every cell
    typedef struct packed {
        logic       en;
        logic [5:0] pad_id;
        logic [7:0] level;
    } t_snoop;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_WAIT,
        S_SEND
    } t_state;

endpackage

### src/pp2m_in_if.sv
// ----------------------------------------------------------------------------
// pp2m_in_if: pad event channel
// Valid/ready channel carrying one pad event word.
// ----------------------------------------------------------------------------
interface pp2m_in_if;
    logic                valid;
    logic                ready;
    pp2m_pkg::t_in_word  word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

### src/pp2m_out_if.sv
// ----------------------------------------------------------------------------
// pp2m_out_if: MIDI message channel
// Valid/ready channel carrying one MIDI message word with LED mark.
// ----------------------------------------------------------------------------
interface pp2m_out_if;
    logic                valid;
    logic                ready;
    pp2m_pkg::t_out_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

### src/pp2m_ram.sv
// ----------------------------------------------------------------------------
// pp2m_ram: generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pp2m_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/pp2m_cell.sv
// ----------------------------------------------------------------------------
// pp2m_cell: one slot of the held-pad chain
// Holds a pad id and its level, shifts toward the head, tracks level updates.
// ----------------------------------------------------------------------------
module pp2m_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  pp2m_pkg::t_entry  i_d,
    input  pp2m_pkg::t_snoop  i_snoop,
    output pp2m_pkg::t_entry  o_q
);
    pp2m_pkg::t_entry r_ent;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_ent <= i_d;
        end else if (i_snoop.en && r_ent.pad_id == i_snoop.pad_id) begin
            r_ent.level <= i_snoop.level;
        end
    end

    assign o_q = r_ent;
endmodule

### src/pp2m_div.sv
// ----------------------------------------------------------------------------
// pp2m_div: restoring divider for pressure scaling
// 16-bit dividend by 9-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pp2m_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_num,
    input  logic [8:0]         i_den,
    output logic               o_busy,
    output logic [6:0]         o_quot
);
    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [8:0]  r_rem;
    logic [15:0] r_num;
    logic [8:0]  r_den;
    logic [9:0]  w_t;
    logic        w_ge;

    assign w_t  = {r_rem, r_num[15]};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? 9'(w_t - {1'b0, r_den}) : w_t[8:0];
            r_num <= {r_num[14:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num[6:0];
endmodule

### src/pad_pressure_to_midi_top.sv
// ----------------------------------------------------------------------------
// pad_pressure_to_midi_top: pad events to MIDI note, pressure and LED words
// Sequencer, level memories, held-pad cell chain and scaling divider.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt takes one pad event word; o_msg gives zero, one or two MIDI words
//   per event, last_result set on the final one. i_cfg_* writes a register
//   (0 use_velocity, 1 pad_mode, 2 mono_cc, 3 octave offset); the user must
//   write it only while idle, the block does not enforce this. One event is
//   in work at a time: i_evt.ready is high only when idle. Flow: accept,
//   lookup of the pad level and note memories, then the held-pad chain
//   rotates once in mono mode, twice on a mono note off while pads are held
//   (first pass fetches the top of stack). The pressure scale divider runs
//   beside the chain, and words go out once it is done. Out-of-range pads
//   are dropped on accept.
//   If o_msg stalls the word holds and no new event is taken.
//   Reset (sync, active low) clears the config and state registers, the valid bits of the
//   level memories and the held count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pad_pressure_to_midi_top #(
    parameter int PAD_COUNT = pp2m_pkg::PAD_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pp2m_in_if.sink     i_evt,
    pp2m_out_if.source  o_msg,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data
);
    localparam int PW = PAD_COUNT > 1 ? $clog2(PAD_COUNT) : 1;
    localparam int CW = $clog2(PAD_COUNT + 1);
    localparam int NW = $clog2(pp2m_pkg::NOTE_COUNT);

    // configuration
    logic       r_use_vel;
    logic [1:0] r_mode;
    logic [6:0] r_mono_cc;
    logic [6:0] r_oct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_vel <= 1'b0;
            r_mode    <= pp2m_pkg::MODE_POLY_AT;
            r_mono_cc <= 7'd1;
            r_oct     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pp2m_pkg::CFG_USE_VELOCITY: r_use_vel <= i_cfg_data[0];
                pp2m_pkg::CFG_PAD_MODE:     r_mode    <= i_cfg_data[1:0];
                pp2m_pkg::CFG_MONO_CC:      r_mono_cc <= i_cfg_data;
                pp2m_pkg::CFG_OCTAVE:       r_oct     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pp2m_pkg::t_state   r_state, n_state;
    pp2m_pkg::t_in_word r_in;

    logic w_accept, w_in_range;
    assign w_accept   = i_evt.valid && i_evt.ready;
    assign w_in_range = {1'b0, i_evt.word.pad_id} < 7'(PAD_COUNT);

    // level memories with reset valid bits
    logic [PAD_COUNT-1:0]            r_lvl_vld;
    logic [pp2m_pkg::NOTE_COUNT-1:0] r_prev_vld;
    logic                            r_lvl_rv, r_prev_rv;
    logic [7:0]                      w_lvl_rd;
    logic [0:0]                      w_prev_rd;
    logic                            w_lvl_we, w_prev_we;

    pp2m_ram #(.WIDTH(8), .DEPTH(PAD_COUNT)) u_lvl_ram (
        .i_clk   (i_clk),
        .i_we    (w_lvl_we),
        .i_waddr (r_in.pad_id[PW-1:0]),
        .i_wdata (r_in.pad_value),
        .i_raddr (i_evt.word.pad_id[PW-1:0]),
        .o_rdata (w_lvl_rd)
    );

    pp2m_ram #(.WIDTH(1), .DEPTH(pp2m_pkg::NOTE_COUNT)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prev_we),
        .i_waddr (r_in.mapped_note[NW-1:0]),
        .i_wdata (r_in.pad_value != 8'd0),
        .i_raddr (i_evt.word.mapped_note[NW-1:0]),
        .o_rdata (w_prev_rd)
    );

    assign w_lvl_we  = (r_state == pp2m_pkg::S_LOOK) && !r_in.velocity_event;
    assign w_prev_we = (r_state == pp2m_pkg::S_LOOK) && r_in.note_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_vld  <= '0;
            r_prev_vld <= '0;
        end else begin
            if (w_lvl_we) r_lvl_vld[r_in.pad_id[PW-1:0]] <= 1'b1;
            if (w_prev_we) r_prev_vld[r_in.mapped_note[NW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in      <= i_evt.word;
            r_lvl_rv  <= r_lvl_vld[i_evt.word.pad_id[PW-1:0]];
            r_prev_rv <= r_prev_vld[i_evt.word.mapped_note[NW-1:0]];
        end
    end

    // event decode (valid in S_LOOK)
    logic [7:0] w_lvl_new;
    logic       w_prev_nz, w_v_nz;
    logic       w_on, w_off, w_press;
    logic       w_push, w_pop, w_scan, w_any;
    logic [CW-1:0] r_cnt;

    assign w_lvl_new = !r_in.velocity_event ? r_in.pad_value : (r_lvl_rv ? w_lvl_rd : 8'd0);
    assign w_prev_nz = r_prev_rv && w_prev_rd[0];
    assign w_v_nz    = r_in.pad_value != 8'd0;

    always_comb begin
        w_on    = 1'b0;
        w_off   = 1'b0;
        w_press = 1'b0;
        if (r_in.note_active) begin
            if (w_v_nz) begin
                if (r_use_vel && r_in.velocity_event) begin
                    w_on = 1'b1;
                end else if (r_use_vel) begin
                    w_press = 1'b1;
                end else if (!w_prev_nz && !r_in.velocity_event) begin
                    w_on    = 1'b1;
                    w_press = 1'b1;
                end else if (w_prev_nz) begin
                    w_press = 1'b1;
                end
            end else if (!r_in.velocity_event) begin
                w_off   = 1'b1;
                w_press = 1'b1;
            end
        end
    end

    assign w_push = w_on && r_mode == pp2m_pkg::MODE_MONO_CC && r_cnt < CW'(PAD_COUNT);
    assign w_pop  = w_off && r_mode == pp2m_pkg::MODE_MONO_CC && r_cnt != '0;
    assign w_scan = r_mode == pp2m_pkg::MODE_MONO_CC && (w_push || w_pop || w_press);
    assign w_any  = w_on || w_off || (w_press && r_mode != pp2m_pkg::MODE_NONE);

    // scaling divider: round(min(v,fs)*127/fs) = (254*vc + fs) / (2*fs)
    logic [7:0]  w_vc;
    logic [15:0] w_num;
    pp2m_pkg::t_div_ctl w_div;
    logic [6:0]  w_quot;

    assign w_vc  = (r_in.pad_value > r_in.full_scale) ? r_in.full_scale : r_in.pad_value;
    assign w_num = 16'({w_vc, 8'd0} - {7'd0, w_vc, 1'b0}) + {8'd0, r_in.full_scale};
    assign w_div.start = (r_state == pp2m_pkg::S_LOOK) && w_press &&
                         r_mode != pp2m_pkg::MODE_NONE && r_in.full_scale != 8'd0;

    pp2m_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div.start),
        .i_num   (w_num),
        .i_den   ({r_in.full_scale, 1'b0}),
        .o_busy  (w_div.busy),
        .o_quot  (w_quot)
    );

    // held-pad chain; cell 0 is the head, processed head re-enters at the tail
    pp2m_pkg::t_entry w_cell_q [PAD_COUNT];
    pp2m_pkg::t_entry w_head_pr;
    pp2m_pkg::t_snoop w_snoop;
    logic             w_shift;

    assign w_shift       = r_state == pp2m_pkg::S_SCAN;
    assign w_snoop.en     = (r_state == pp2m_pkg::S_LOOK) && !r_in.velocity_event;
    assign w_snoop.pad_id = r_in.pad_id;
    assign w_snoop.level  = r_in.pad_value;

    for (genvar g = 0; g < PAD_COUNT; g++) begin : g_cell
        pp2m_pkg::t_entry w_d;
        if (g == PAD_COUNT - 1) begin : g_tail
            assign w_d = w_head_pr;
        end else begin : g_mid
            assign w_d = w_cell_q[g+1];
        end
        pp2m_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_d     (w_d),
            .i_snoop (w_snoop),
            .o_q     (w_cell_q[g])
        );
    end

    logic [PW-1:0]    r_step;
    logic             r_pass;      // 0: fetch top of stack, 1: apply and take max
    logic             r_push, r_pop_pend, r_found;
    logic             r_on, r_off, r_press;
    logic [7:0]       r_max, r_lvl_new;
    pp2m_pkg::t_entry r_top;

    logic w_live, w_is_top, w_hit, w_incl, w_is_push;

    assign w_live    = CW'(r_step) < r_cnt;
    assign w_is_top  = CW'(r_step) + CW'(1) == r_cnt;
    assign w_is_push = r_push && CW'(r_step) == r_cnt;
    assign w_hit     = r_pass && r_pop_pend && w_live && w_cell_q[0].pad_id == r_in.pad_id;

    always_comb begin
        w_head_pr = w_cell_q[0];
        w_incl    = w_live;
        if (r_pass) begin
            if (w_hit) begin
                w_head_pr = r_top;
            end
            if ((w_hit || r_found) && w_is_top) begin
                w_incl = 1'b0;
            end
            if (w_is_push) begin
                w_head_pr = '{pad_id: r_in.pad_id, level: r_lvl_new};
                w_incl    = 1'b1;
            end
        end
    end

    // results
    logic [8:0]          w_note;
    logic                w_ok, w_pemit;
    logic [6:0]          w_n7;
    pp2m_pkg::t_out_word w_nmsg, w_pmsg;
    pp2m_pkg::t_out_word r_res0, r_res1;
    logic                r_nres, r_ridx;   // nres: 1 means two words

    assign w_note = 9'($signed({2'b00, r_in.mapped_note}) + $signed({{2{r_oct[6]}}, r_oct}));
    assign w_ok   = w_note[8:7] == 2'b00;
    assign w_n7   = w_note[6:0];

    always_comb begin
        case (r_mode)
            pp2m_pkg::MODE_MONO_CC: w_pemit = r_press && r_in.pad_value >= r_max;
            pp2m_pkg::MODE_POLY_AT,
            pp2m_pkg::MODE_POLY_CC: w_pemit = r_press;
            default:                w_pemit = 1'b0;
        endcase

        w_nmsg.msg_valid   = w_ok;
        w_nmsg.status_byte = w_ok ? ((r_on ? pp2m_pkg::ST_NOTE_ON : pp2m_pkg::ST_NOTE_OFF)
                                     | {4'd0, r_in.event_channel}) : 8'd0;
        w_nmsg.data_one    = w_ok ? w_n7 : 7'd0;
        w_nmsg.data_two    = (w_ok && r_on) ?
                             (r_use_vel ? r_in.pad_value[6:0] : pp2m_pkg::VEL_FIXED) : 7'd0;
        w_nmsg.led_action  = r_on ? pp2m_pkg::LED_ON : pp2m_pkg::LED_OFF;
        w_nmsg.last_result = !w_pemit;

        w_pmsg.msg_valid   = 1'b1;
        w_pmsg.status_byte = ((r_mode == pp2m_pkg::MODE_POLY_AT) ? pp2m_pkg::ST_POLY_AT
                              : pp2m_pkg::ST_CC) | {4'd0, r_in.event_channel};
        w_pmsg.data_one    = (r_mode == pp2m_pkg::MODE_MONO_CC) ? r_mono_cc : w_n7;
        w_pmsg.data_two    = (r_in.full_scale == 8'd0) ? 7'd0 : w_quot;
        w_pmsg.led_action  = pp2m_pkg::LED_NONE;
        w_pmsg.last_result = 1'b1;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pp2m_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_evt.ready = 1'b0;
        o_msg.valid = 1'b0;
        o_msg.word  = r_ridx ? r_res1 : r_res0;
        case (r_state)
            pp2m_pkg::S_IDLE: begin
                i_evt.ready = 1'b1;
                if (i_evt.valid && w_in_range) n_state = pp2m_pkg::S_LOOK;
            end
            pp2m_pkg::S_LOOK: begin
                if (!w_any && !w_scan) n_state = pp2m_pkg::S_IDLE;
                else if (w_scan)       n_state = pp2m_pkg::S_SCAN;
                else                   n_state = pp2m_pkg::S_WAIT;
            end
            pp2m_pkg::S_SCAN: begin
                if (r_pass && r_step == PW'(PAD_COUNT - 1)) n_state = pp2m_pkg::S_WAIT;
            end
            pp2m_pkg::S_WAIT: begin
                if (!w_div.busy) begin
                    if ((r_on || r_off) || w_pemit) n_state = pp2m_pkg::S_SEND;
                    else                            n_state = pp2m_pkg::S_IDLE;
                end
            end
            pp2m_pkg::S_SEND: begin
                o_msg.valid = 1'b1;
                if (o_msg.ready && r_ridx == r_nres) n_state = pp2m_pkg::S_IDLE;
            end
            default: n_state = pp2m_pkg::S_IDLE;
        endcase
    end

    // held count, the only control state of the stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == pp2m_pkg::S_SCAN && r_pass &&
                     r_step == PW'(PAD_COUNT - 1)) begin
            r_cnt <= r_cnt + CW'(r_push) - CW'(r_found || w_hit);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            pp2m_pkg::S_LOOK: begin
                r_on       <= w_on;
                r_off      <= w_off;
                r_press    <= w_press;
                r_push     <= w_push;
                r_pop_pend <= w_pop;
                r_found    <= 1'b0;
                r_pass     <= !w_pop;
                r_step     <= '0;
                r_max      <= '0;
                r_lvl_new  <= w_lvl_new;
            end
            pp2m_pkg::S_SCAN: begin
                if (!r_pass && w_is_top) r_top <= w_cell_q[0];
                if (w_hit) begin
                    r_pop_pend <= 1'b0;
                    r_found    <= 1'b1;
                end
                if (r_pass && w_incl && w_head_pr.level > r_max) r_max <= w_head_pr.level;
                if (r_step == PW'(PAD_COUNT - 1)) begin
                    r_step <= '0;
                    r_pass <= 1'b1;
                end else begin
                    r_step <= r_step + PW'(1);
                end
            end
            pp2m_pkg::S_WAIT: begin
                r_ridx <= 1'b0;
                if (r_on || r_off) begin
                    r_res0 <= w_nmsg;
                    r_res1 <= w_pmsg;
                    r_nres <= w_pemit;
                end else begin
                    r_res0 <= w_pmsg;
                    r_nres <= 1'b0;
                end
            end
            pp2m_pkg::S_SEND: begin
                if (o_msg.ready) r_ridx <= 1'b1;
            end
            default: ;
        endcase
    end

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(PAD_COUNT))
        else $error("held count above pad count");

    a_seq_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.ready |-> !o_msg.valid)
        else $error("event taken while a word is pending");

    a_led_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg.valid && !o_msg.word.msg_valid |-> o_msg.word.led_action != pp2m_pkg::LED_NONE)
        else $error("suppressed message without LED mark");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg.valid |-> !w_div.busy)
        else $error("word sent before scaling finished");

endmodule

### verif/pp2m_checker.sv
// ----------------------------------------------------------------------------
// pp2m_checker: MIDI word predictor and scoreboard
// Watches the event and message channels, models the pad state and compares
// every delivered MIDI word with the oldest predicted one.
// ----------------------------------------------------------------------------
module pp2m_checker
    import pp2m_pkg::*;
#(
    parameter int PAD_COUNT = PAD_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_evt_valid,
    input  logic        i_evt_ready,
    input  t_in_word    i_evt_word,
    input  logic        i_msg_valid,
    input  logic        i_msg_ready,
    input  t_out_word   i_msg_word,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_words
);

    logic       use_vel;
    logic [1:0] mode;
    logic [6:0] cc_num;
    logic [6:0] oct;

    logic [5:0] held [PAD_COUNT];
    int         held_n;
    logic [7:0] level [PAD_COUNT];
    logic [7:0] prev_lvl [NOTE_COUNT];

    t_out_word  midi_q [$];
    t_out_word  burst [$];

    assign o_pending = midi_q.size();

    function automatic logic [6:0] scaled(input int v, input int fs);
        if (fs == 0) return 7'd0;
        if (v > fs) v = fs;
        return 7'((2 * v * 127 + fs) / (2 * fs));
    endfunction

    task automatic add_word(input logic vld, input logic [7:0] st, input logic [6:0] d1,
                            input logic [6:0] d2, input logic [1:0] led);
        t_out_word w;
        w.msg_valid   = vld;
        w.status_byte = vld ? st : 8'd0;
        w.data_one    = vld ? d1 : 7'd0;
        w.data_two    = vld ? d2 : 7'd0;
        w.led_action  = led;
        w.last_result = 1'b0;
        burst.push_back(w);
    endtask

    task automatic pressure(input logic [3:0] ch, input logic [6:0] nt, input int v,
                            input int fs);
        int mx;
        mx = 0;
        case (mode)
            MODE_MONO_CC: begin
                for (int i = 0; i < held_n; i++)
                    if (level[held[i]] > mx) mx = level[held[i]];
                if (v >= mx) add_word(1'b1, ST_CC | ch, cc_num, scaled(v, fs), LED_NONE);
            end
            MODE_POLY_AT: add_word(1'b1, ST_POLY_AT | ch, nt, scaled(v, fs), LED_NONE);
            MODE_POLY_CC: add_word(1'b1, ST_CC | ch, nt, scaled(v, fs), LED_NONE);
            default: ;
        endcase
    endtask

    task automatic predict(input t_in_word e);
        int  note, v, fs, k;
        logic ok;
        logic [6:0] n7;
        logic [3:0] ch;
        burst.delete();
        if (e.pad_id >= PAD_COUNT) return;
        if (!e.velocity_event) level[e.pad_id] = e.pad_value;
        if (!e.note_active) return;
        note = int'(e.mapped_note) + int'($signed(oct));
        ok   = note >= 0 && note < 128;
        n7   = 7'(note);
        v    = e.pad_value;
        fs   = e.full_scale;
        ch   = e.event_channel;
        if (v > 0) begin
            if (use_vel && e.velocity_event) begin
                add_word(ok, ST_NOTE_ON | ch, n7, 7'(v), LED_ON);
                if (mode == MODE_MONO_CC && held_n < PAD_COUNT) held[held_n++] = e.pad_id;
            end else if (use_vel) begin
                pressure(ch, n7, v, fs);
            end else if (prev_lvl[e.mapped_note] == 0 && !e.velocity_event) begin
                add_word(ok, ST_NOTE_ON | ch, n7, VEL_FIXED, LED_ON);
                if (mode == MODE_MONO_CC && held_n < PAD_COUNT) held[held_n++] = e.pad_id;
                pressure(ch, n7, v, fs);
            end else if (prev_lvl[e.mapped_note] > 0) begin
                pressure(ch, n7, v, fs);
            end
        end else if (!e.velocity_event) begin
            add_word(ok, ST_NOTE_OFF | ch, n7, 7'd0, LED_OFF);
            if (mode == MODE_MONO_CC) begin
                k = -1;
                for (int i = 0; i < held_n; i++)
                    if (k < 0 && held[i] == e.pad_id) k = i;
                if (k >= 0) begin
                    for (int i = k; i + 1 < held_n; i++) held[i] = held[i + 1];
                    held_n--;
                end
            end
            pressure(ch, n7, 0, fs);
        end
        prev_lvl[e.mapped_note] = e.pad_value;
        if (burst.size() > 0) burst[burst.size() - 1].last_result = 1'b1;
        foreach (burst[i]) midi_q.push_back(burst[i]);
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            use_vel  <= 1'b0;
            mode     <= MODE_POLY_AT;
            cc_num   <= 7'd1;
            oct      <= 7'd0;
            held_n   = 0;
            o_errors <= 0;
            o_words  <= 0;
            for (int i = 0; i < PAD_COUNT; i++) level[i] = 8'd0;
            for (int i = 0; i < NOTE_COUNT; i++) prev_lvl[i] = 8'd0;
            midi_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_USE_VELOCITY: use_vel <= i_cfg_data[0];
                    CFG_PAD_MODE:     mode    <= i_cfg_data[1:0];
                    CFG_MONO_CC:      cc_num  <= i_cfg_data;
                    CFG_OCTAVE:       oct     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_msg_valid && i_msg_ready) begin
                o_words <= o_words + 1;
                if (midi_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected MIDI word %h", i_msg_word);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = midi_q.pop_front();
                    if (exp_w !== i_msg_word) begin
                        if (o_errors < 10)
                            $display({"mismatch: exp v%b st%h d1 %0d d2 %0d led%0d l%b,",
                                      " got v%b st%h d1 %0d d2 %0d led%0d l%b"},
                                     exp_w.msg_valid, exp_w.status_byte, exp_w.data_one,
                                     exp_w.data_two, exp_w.led_action, exp_w.last_result,
                                     i_msg_word.msg_valid, i_msg_word.status_byte,
                                     i_msg_word.data_one, i_msg_word.data_two,
                                     i_msg_word.led_action, i_msg_word.last_result);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_evt_valid && i_evt_ready) predict(i_evt_word);
        end
    end

endmodule

### verif/tb_pad_pressure_to_midi_top.sv
// ----------------------------------------------------------------------------
// tb_pad_pressure_to_midi_top: stimulus and verdict for the pad to MIDI block
// Drives directed and random pad events across register settings with random
// gaps and stalls; a side checker predicts and compares every MIDI word.
// ----------------------------------------------------------------------------
module tb_pad_pressure_to_midi_top;
    import pp2m_pkg::*;

    localparam int PADS      = PAD_COUNT_DEF;
    localparam int DOG_LIMIT = 20000;   // mono off with both chain passes plus long stalls

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [6:0] i_cfg_data;

    pp2m_in_if  evt_if ();
    pp2m_out_if msg_if ();

    int errors, pending, words;
    int sent;
    int idle_cycles;

    pad_pressure_to_midi_top #(.PAD_COUNT(PADS)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_if.sink),
        .o_msg      (msg_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    pp2m_checker #(.PAD_COUNT(PADS)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_if.valid),
        .i_evt_ready (evt_if.ready),
        .i_evt_word  (evt_if.word),
        .i_msg_valid (msg_if.valid),
        .i_msg_ready (msg_if.ready),
        .i_msg_word  (msg_if.word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_words     (words)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stall pattern, independent of the sender
    initial begin
        int g;
        msg_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            msg_if.ready <= 1'b1;
            @(negedge i_clk);
            g = gap_len();
            if (g > 0) begin
                msg_if.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
    end

    // watchdog: any cycle without a handshake counts toward the limit
    always @(posedge i_clk) begin
        if (!i_rst_n || (evt_if.valid && evt_if.ready) || (msg_if.valid && msg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= DOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", DOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [6:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // drain then let the longest mono pass finish before touching registers
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (2 * PADS + 40) @(negedge i_clk);
    endtask

    // called at a falling edge; ready is stable there, so the word is taken
    // at the next rising edge once ready is seen high
    task automatic send_event(input t_in_word w);
        int g;
        g = gap_len();
        if (g > 0) begin
            evt_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        evt_if.valid <= 1'b1;
        evt_if.word  <= w;
        while (!evt_if.ready) @(negedge i_clk);
        @(negedge i_clk);
        evt_if.valid <= 1'b0;
        sent++;
    endtask

    function automatic t_in_word mk(input int pad, input int val, input logic vel,
                                    input int note, input logic act, input int fs);
        t_in_word w;
        w.pad_id         = 6'(pad);
        w.pad_value      = 8'(val);
        w.velocity_event = vel;
        w.event_channel  = 4'($urandom_range(0, 15));
        w.mapped_note    = 7'(note);
        w.note_active    = act;
        w.full_scale     = 8'(fs);
        return w;
    endfunction

    // one press/pressure sequence on a pad, usually ended by a release, random content
    task automatic play_pad();
        int pad, note, fs, n;
        pad  = $urandom_range(0, PADS - 1);
        note = $urandom_range(0, 127);
        fs   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255);
        if ($urandom_range(0, 1))
            send_event(mk(pad, $urandom_range(1, 255), 1'b1, note, 1'b1, fs));
        n = $urandom_range(1, 4);
        repeat (n) send_event(mk(pad, $urandom_range(1, 255), 1'b0, note, 1'b1, fs));
        if ($urandom_range(0, 3) != 0)
            send_event(mk(pad, 0, 1'b0, note, 1'b1, fs));
    endtask

    task automatic random_event();
        t_in_word w;
        w = t_in_word'({$urandom, $urandom});
        if ($urandom_range(0, 9) != 0) w.pad_id = 6'($urandom_range(0, PADS - 1));
        if ($urandom_range(0, 5) == 0) w.pad_value = 8'd0;
        send_event(w);
    endtask

    initial begin
        int phase;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_USE_VELOCITY;
        i_cfg_data   = 7'd0;
        evt_if.valid = 1'b0;
        evt_if.word  = '0;
        sent         = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings (poly aftertouch, fixed velocity)
        send_event(mk(0, 255, 1'b0, 60, 1'b1, 255));   // note on + pressure
        send_event(mk(0, 200, 1'b0, 60, 1'b1, 100));   // value above full scale
        send_event(mk(0, 50, 1'b0, 60, 1'b1, 0));      // zero full scale
        send_event(mk(0, 77, 1'b1, 60, 1'b1, 200));    // velocity, prev set
        send_event(mk(0, 0, 1'b0, 60, 1'b1, 200));     // note off
        send_event(mk(1, 90, 1'b1, 61, 1'b1, 200));    // velocity, prev zero
        send_event(mk(1, 0, 1'b1, 61, 1'b1, 200));     // velocity zero
        send_event(mk(63, 99, 1'b0, 62, 1'b1, 200));   // pad out of range
        send_event(mk(48, 99, 1'b0, 62, 1'b1, 200));
        send_event(mk(2, 99, 1'b0, 62, 1'b0, 200));    // unmapped pad
        drain();
        // out-of-range notes with extreme offsets
        cfg_write(CFG_OCTAVE, 7'(48));
        send_event(mk(3, 10, 1'b0, 127, 1'b1, 255));
        send_event(mk(3, 0, 1'b0, 127, 1'b1, 255));
        drain();
        cfg_write(CFG_OCTAVE, 7'(-48));
        send_event(mk(4, 10, 1'b0, 0, 1'b1, 1));
        send_event(mk(4, 0, 1'b0, 0, 1'b1, 1));
        drain();
        // velocity mode, wide velocity, mono CC with a held stack
        cfg_write(CFG_USE_VELOCITY, 7'd1);
        cfg_write(CFG_PAD_MODE, 7'(MODE_MONO_CC));
        cfg_write(CFG_MONO_CC, 7'd127);
        cfg_write(CFG_OCTAVE, 7'd0);
        send_event(mk(5, 200, 1'b1, 40, 1'b1, 255));
        send_event(mk(6, 127, 1'b1, 41, 1'b1, 255));
        send_event(mk(5, 150, 1'b0, 40, 1'b1, 255));
        send_event(mk(6, 20, 1'b0, 41, 1'b1, 255));    // not the loudest
        send_event(mk(7, 0, 1'b0, 42, 1'b1, 255));     // pop of absent pad
        send_event(mk(5, 0, 1'b0, 40, 1'b1, 255));
        send_event(mk(6, 0, 1'b0, 41, 1'b1, 255));
        drain();
        // fill the stack past full
        for (int p = 0; p < PADS + 2; p++)
            send_event(mk(p % PADS, 1 + p, 1'b1, p, 1'b1, 200));
        send_event(mk(9, 0, 1'b0, 9, 1'b1, 200));
        drain();

        // random phases over register settings; extremes included
        for (phase = 0; phase < 12; phase++) begin
            cfg_write(CFG_USE_VELOCITY, 7'(phase % 2));
            cfg_write(CFG_PAD_MODE, 7'((phase / 2) % 4));
            cfg_write(CFG_MONO_CC, (phase < 2) ? 7'(phase * 127) : 7'($urandom_range(0, 127)));
            cfg_write(CFG_OCTAVE, (phase == 3) ? 7'(48) : (phase == 4) ? 7'(-48)
                                 : 7'($urandom_range(0, 24) - 12));
            repeat (22) begin
                if ($urandom_range(0, 4) != 0) play_pad();
                else random_event();
            end
            if (phase == 5) begin
                // sender holds off until every word is out
                while (pending != 0) @(negedge i_clk);
            end
            drain();
        end

        $display("sent %0d pad events, checked %0d MIDI words over all modes", sent, words);
        $display("velocity on/off, offsets +-48, stack overflow and absent pops covered");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
